// ===== rtl/inoalloc_pkg.sv =====
// ----------------------------------------------------------------------------
// Entry number allocator package
// Shared constants, operation and status codes, and the word search helper
// used by the first-free entry number allocator.
// ----------------------------------------------------------------------------
package inoalloc_pkg;

    // Default sizing of the allocator.
    localparam int ENTRY_COUNT_DEF = 256;
    localparam int ROOT_NUMBER_DEF = 1;
    localparam int BLOCK_BITS_DEF  = 16;

    // Widths of the item fields on the ports.
    localparam int OP_W       = 2;
    localparam int ENTRY_IN_W = 16;
    localparam int BLOCK_IN_W = 16;
    localparam int STATUS_W   = 2;
    localparam int ALLOC_W    = 8;
    localparam int MAP_W      = 16;
    localparam int FREE_OUT_W = 9;

    // The used map is kept as words of this many bits.
    localparam int WORD_W = 32;
    localparam int BIT_AW = $clog2(WORD_W);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    // Position of the lowest clear bit of a word; zero for a full word.
    function automatic logic [BIT_AW-1:0] first_zero(input logic [WORD_W-1:0] word);
        logic [BIT_AW-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!word[i]) begin
                idx = BIT_AW'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/inode_number_allocator_with_map_unit.sv =====
// ----------------------------------------------------------------------------
// First-free entry number allocator with block map
// Hands out the lowest free entry number, keeps a block number for each
// entry, and answers release and lookup requests with a running free count.
// ----------------------------------------------------------------------------
// How to use it: after reset the block runs a clearing pass over its two
// memories, with s_tready low, and then accepts one request item at a time.
// A release or a lookup goes through its working state and the done state
// before the next acceptance, and a request that is rejected at once (bad
// number, bad operation, no free count) goes straight to the done state. An
// allocate scans the used map one 32-bit word per cycle through a single
// read port and priority encoder, from word 0 up to the word that holds the
// lowest free number or up to the last word. A stalled result channel
// holds the block in the done state only when a new result is ready while
// the previous one waits; the next request is accepted while a result waits.
// ----------------------------------------------------------------------------
module inode_number_allocator_with_map_unit #(
    parameter int ENTRY_COUNT = inoalloc_pkg::ENTRY_COUNT_DEF,
    parameter int ROOT_NUMBER = inoalloc_pkg::ROOT_NUMBER_DEF,
    parameter int BLOCK_BITS  = inoalloc_pkg::BLOCK_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] entry_number, [31:16] block_number
    input  logic [31:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] allocated_number, [23:8] mapped_block, [32:24] free_count,
    // [39:33] zero
    output logic [39:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser
);

    import inoalloc_pkg::*;

    // Sizing derived from the parameters.
    localparam int ENT_AW     = $clog2(ENTRY_COUNT);
    localparam int ENT_DEPTH  = 1 << ENT_AW;
    localparam int WORDS      = (ENTRY_COUNT + WORD_W - 1) / WORD_W;
    localparam int WORD_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WORD_DEPTH = 1 << WORD_AW;
    localparam int N_W        = WORD_AW + BIT_AW;
    localparam int FREE_W     = $clog2(ENTRY_COUNT + 1);
    localparam int BLK_W      = (BLOCK_BITS < BLOCK_IN_W) ? BLOCK_BITS : BLOCK_IN_W;
    localparam int TAIL_BITS  = ENTRY_COUNT - (WORDS - 1) * WORD_W;

    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORDS - 1);
    // Bits of the last word that lie past the end of the number range.
    localparam logic [WORD_W-1:0] TAIL_MASK =
        ~WORD_W'(((WORD_W + 1)'(1) << TAIL_BITS) - (WORD_W + 1)'(1));
    // Reserved numbers 0 through ROOT_NUMBER start out used.
    localparam logic [WORD_W-1:0] INIT_WORD0 =
        WORD_W'(((WORD_W + 1)'(1) << (ROOT_NUMBER + 1)) - (WORD_W + 1)'(1));

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_SCAN     = 8'b0000_0100,
        S_REL_WR   = 8'b0000_1000,
        S_LOOK     = 8'b0001_0000,
        S_DONE     = 8'b0010_0000,
        S_SPARE_A  = 8'b0100_0000,
        S_SPARE_B  = 8'b1000_0000
    } state_t;

    // Control state.
    state_t              state_reg, state_next;
    logic [ENT_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [FREE_W-1:0]   free_reg, free_next;
    logic                chk_valid_reg, chk_valid_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // Scan and result payload.
    logic [WORD_AW-1:0]  scan_addr_reg, scan_addr_next;
    logic [WORD_AW-1:0]  chk_addr_reg, chk_addr_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [N_W-1:0]      res_num_reg, res_num_next;
    logic [BLK_W-1:0]    res_map_reg, res_map_next;

    // Latched request fields.
    logic [N_W-1:0]      num_idx_reg;
    logic [BLK_W-1:0]    blk_reg;

    // Output registers.
    logic [STATUS_W-1:0] out_status_reg;
    logic [N_W-1:0]      out_num_reg;
    logic [BLK_W-1:0]    out_map_reg;
    logic [FREE_W-1:0]   out_free_reg;
    logic                out_load;

    // Memories and their ports.
    logic [WORD_W-1:0]   used_mem [0:WORD_DEPTH-1];
    logic [BLK_W-1:0]    blk_mem  [0:ENT_DEPTH-1];
    logic [WORD_W-1:0]   used_rd_reg;
    logic [BLK_W-1:0]    blk_rd_reg;
    logic [WORD_AW-1:0]  used_raddr;
    logic                used_we;
    logic [WORD_AW-1:0]  used_waddr;
    logic [WORD_W-1:0]   used_wdata;
    logic                blk_we;
    logic [ENT_AW-1:0]   blk_waddr;
    logic [BLK_W-1:0]    blk_wdata;

    // Request decode.
    logic [OP_W-1:0]       in_op;
    logic [ENTRY_IN_W-1:0] in_entry;
    logic [BLOCK_IN_W-1:0] in_block;
    logic [N_W-1:0]        in_idx;
    logic                  in_below_end;
    logic                  accept;

    // Word search.
    logic [WORD_W-1:0]   scan_word;
    logic                scan_full;
    logic [BIT_AW-1:0]   scan_bit;
    logic [N_W-1:0]      scan_num;

    assign in_op        = s_tuser;
    assign in_entry     = s_tdata[15:0];
    assign in_block     = s_tdata[31:16];
    assign in_idx       = N_W'(in_entry);
    assign in_below_end = (17'(in_entry) < 17'(ENTRY_COUNT));
    assign accept       = s_tvalid && s_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'b0, FREE_OUT_W'(out_free_reg), MAP_W'(out_map_reg),
                       ALLOC_W'(out_num_reg)};

    // The tail of the last word is forced to look used so the search never
    // returns a number past the end of the range.
    assign scan_word = used_rd_reg | ((chk_addr_reg == LAST_WORD) ? TAIL_MASK : '0);
    assign scan_full = &scan_word;
    assign scan_bit  = first_zero(scan_word);
    assign scan_num  = {chk_addr_reg, scan_bit};

    // The scan walks the words; otherwise the word that holds the request's
    // number is read while the request is accepted.
    assign used_raddr = (state_reg == S_SCAN) ? scan_addr_reg : in_idx[N_W-1:BIT_AW];

    always_ff @(posedge aclk) begin
        if (used_we) begin
            used_mem[used_waddr] <= used_wdata;
        end
        used_rd_reg <= used_mem[used_raddr];
    end

    always_ff @(posedge aclk) begin
        if (blk_we) begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        blk_rd_reg <= blk_mem[in_idx[ENT_AW-1:0]];
    end

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        free_next       = free_reg;
        chk_valid_next  = 1'b0;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        scan_addr_next  = scan_addr_reg;
        chk_addr_next   = chk_addr_reg;
        res_status_next = res_status_reg;
        res_num_next    = res_num_reg;
        res_map_next    = res_map_reg;
        out_load        = 1'b0;
        used_we         = 1'b0;
        used_waddr      = num_idx_reg[N_W-1:BIT_AW];
        used_wdata      = used_rd_reg;
        blk_we          = 1'b0;
        blk_waddr       = num_idx_reg[ENT_AW-1:0];
        blk_wdata       = '0;

        unique case (state_reg)
            S_CLEAR: begin
                // One map entry per cycle; the used words go along while the
                // counter is still inside the word range.
                blk_we    = 1'b1;
                blk_waddr = clr_cnt_reg;
                if ({1'b0, clr_cnt_reg} < (ENT_AW + 1)'(WORDS)) begin
                    used_we    = 1'b1;
                    used_waddr = WORD_AW'(clr_cnt_reg);
                    used_wdata = (clr_cnt_reg == '0) ? INIT_WORD0 : '0;
                end
                clr_cnt_next = clr_cnt_reg + ENT_AW'(1);
                if (clr_cnt_reg == ENT_AW'(ENTRY_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    res_status_next = STAT_RANGE;
                    res_num_next    = '0;
                    res_map_next    = '0;
                    state_next      = S_DONE;
                    case (in_op)
                        OP_ALLOC: begin
                            if (free_reg == '0) begin
                                res_status_next = STAT_NONE;
                            end else begin
                                scan_addr_next = '0;
                                state_next     = S_SCAN;
                            end
                        end
                        OP_RELEASE: begin
                            if (in_entry != '0 && in_below_end) begin
                                state_next = S_REL_WR;
                            end
                        end
                        OP_LOOKUP: begin
                            if (in_entry >= ENTRY_IN_W'(ROOT_NUMBER) && in_below_end) begin
                                state_next = S_LOOK;
                            end
                        end
                        default: begin
                            // Unknown operation: reported as out of range.
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Reads are issued every cycle; the word from the previous read, now in the
                // read register, is checked here.
                scan_addr_next = scan_addr_reg + WORD_AW'(1);
                chk_addr_next  = scan_addr_reg;
                chk_valid_next = 1'b1;
                if (chk_valid_reg) begin
                    if (!scan_full) begin
                        chk_valid_next = 1'b0;
                        state_next     = S_DONE;
                        if (scan_num <= N_W'(ROOT_NUMBER)) begin
                            // A reserved number was released and is lowest.
                            res_status_next = STAT_RANGE;
                        end else begin
                            used_we         = 1'b1;
                            used_waddr      = chk_addr_reg;
                            used_wdata      = used_rd_reg | (WORD_W'(1) << scan_bit);
                            blk_we          = 1'b1;
                            blk_waddr       = scan_num[ENT_AW-1:0];
                            blk_wdata       = blk_reg;
                            free_next       = free_reg - FREE_W'(1);
                            res_status_next = STAT_OK;
                            res_num_next    = scan_num;
                        end
                    end else if (chk_addr_reg == LAST_WORD) begin
                        chk_valid_next  = 1'b0;
                        res_status_next = STAT_NONE;
                        state_next      = S_DONE;
                    end
                end
            end

            S_REL_WR: begin
                used_we    = 1'b1;
                used_wdata = used_rd_reg & ~(WORD_W'(1) << num_idx_reg[BIT_AW-1:0]);
                blk_we     = 1'b1;
                if (free_reg != FREE_W'(ENTRY_COUNT)) begin
                    free_next = free_reg + FREE_W'(1);
                end
                res_status_next = STAT_OK;
                state_next      = S_DONE;
            end

            S_LOOK: begin
                res_map_next    = blk_rd_reg;
                res_status_next = STAT_OK;
                state_next      = S_DONE;
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            free_reg      <= FREE_W'(ENTRY_COUNT - ROOT_NUMBER - 1);
            chk_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            free_reg      <= free_next;
            chk_valid_reg <= chk_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_addr_reg  <= scan_addr_next;
        chk_addr_reg   <= chk_addr_next;
        res_status_reg <= res_status_next;
        res_num_reg    <= res_num_next;
        res_map_reg    <= res_map_next;
        if (accept) begin
            num_idx_reg <= in_idx;
            blk_reg     <= BLK_W'(in_block);
        end
        if (out_load) begin
            out_status_reg <= res_status_reg;
            out_num_reg    <= res_num_reg;
            out_map_reg    <= res_map_reg;
            out_free_reg   <= free_reg;
        end
    end

    // The free count never climbs past the number of entries.
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= FREE_W'(ENTRY_COUNT))
        else $error("free count above entry count");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in work");

    // The free count only moves while an item is being worked on.
    a_free_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && $past(s_tready) |-> $stable(free_reg))
        else $error("free count changed while idle");

endmodule
